/* hw/rtl/chcb_pkg.sv */
`timescale 1ns / 1ps

package chcb_pkg;

	localparam int TEMP_FRAC_BITS_DEF = 6;

	localparam int IN_W     = 16;
	localparam int MOL_W    = 16;
	localparam int X_W      = 20;
	localparam int KB_W     = 34;
	localparam int KH_W     = 44;
	localparam int E_W      = 34;
	localparam int Y_W      = 36;
	localparam int N_W      = 8;
	localparam int F_W      = 28;
	localparam int Z_W      = 30;
	localparam int R_W      = 32;
	localparam int W_W      = 31;
	localparam int P_W      = 26;
	localparam int V_W      = 64;
	localparam int HENRY_W  = 40;
	localparam int KH_STEPS = 5;
	localparam int EXP_TERMS = 12;

	localparam logic [V_W-1:0] OUT_MAX = (64'd1 << HENRY_W) - 64'd1;

	// Kh coefficients in powers of x = t/512, pascals Q4
	localparam logic signed [KH_W-1:0] KH_COEF [0:5] = '{
		KH_W'(64'd78366600 * 64'd16),
		KH_W'(64'd1960250 * 64'd8192),
		KH_W'(((64'd820574 << 22) + 64'd5) / 64'd10),
		KH_W'(64'd0 - (((64'd740674 << 28) + 64'd62) / 64'd125)),
		KH_W'(((64'd21838 << 36) + 64'd312) / 64'd625),
		KH_W'(64'd0 - (((64'd220999 << 41) + 64'd195312) / 64'd390625))
	};

	localparam logic [63:0] KB4A = 64'd108233 << 25;
	localparam logic [63:0] KB4Q = KB4A / 64'd390625;
	localparam logic [63:0] KB4R = KB4A % 64'd390625;

	// kb coefficients in powers of x = t/512, Q30
	localparam logic signed [KB_W-1:0] KB_COEF [0:4] = '{
		KB_W'(((64'd119784 << 24) + 64'd7812) / 64'd15625),
		KB_W'(64'd0 - (((64'd717823 << 30) + 64'd976562) / 64'd1953125)),
		KB_W'(((64'd493854 << 37) + 64'd24414062) / 64'd48828125),
		KB_W'(64'd0 - (((64'd103826 << 44) + 64'd610351562) / 64'd1220703125)),
		KB_W'(((KB4Q << 25) + ((KB4R << 25) / 64'd390625) + 64'd195312) / 64'd390625)
	};

	localparam logic [31:0]    LOG2_10_Q30 = 32'd3566893132;
	localparam logic [Z_W-1:0] LN2_Q30     = 30'd744261118;
	localparam logic [R_W-1:0] ONE_Q30     = 32'd1 << 30;

	// floor(w / k) = (w * M) >> S, exact for 31-bit w
	localparam logic [31:0] RECIP_M [1:12] = '{
		32'((64'd1 << 31) / 64'd1 + 64'd1),
		32'((64'd1 << 32) / 64'd2 + 64'd1),
		32'((64'd1 << 33) / 64'd3 + 64'd1),
		32'((64'd1 << 33) / 64'd4 + 64'd1),
		32'((64'd1 << 34) / 64'd5 + 64'd1),
		32'((64'd1 << 34) / 64'd6 + 64'd1),
		32'((64'd1 << 34) / 64'd7 + 64'd1),
		32'((64'd1 << 34) / 64'd8 + 64'd1),
		32'((64'd1 << 35) / 64'd9 + 64'd1),
		32'((64'd1 << 35) / 64'd10 + 64'd1),
		32'((64'd1 << 35) / 64'd11 + 64'd1),
		32'((64'd1 << 35) / 64'd12 + 64'd1)
	};
	localparam int RECIP_S [1:12] = '{31, 32, 33, 33, 34, 34, 34, 34, 35, 35, 35, 35};

	typedef struct packed {
		logic [X_W-1:0]          x;
		logic [MOL_W-1:0]        mol;
		logic                    clamped;
		logic signed [KH_W-1:0]  kh;
		logic signed [KB_W-1:0]  kb;
	} chcb_hrn_t;

	typedef struct packed {
		logic [Z_W-1:0]          z;
		logic [R_W-1:0]          r;
		logic signed [N_W-1:0]   n;
		logic signed [KH_W-1:0]  kh;
		logic                    clamped;
	} chcb_exp_t;

endpackage

/* hw/rtl/chcb_horner_cell.sv */
`timescale 1ns / 1ps

module chcb_horner_cell import chcb_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      in_valid,
	input  chcb_hrn_t in_data,
	output logic      out_valid,
	output chcb_hrn_t out_data
);

	logic signed [KH_W+X_W:0] kh_prod;
	logic signed [KB_W-1:0]   kb_next;
	logic                     valid_q;
	chcb_hrn_t                data_q;

	assign kh_prod = in_data.kh * $signed({1'b0, in_data.x});

	generate
		if (STEP == 0) begin : g_kb_hold
			// kb has one step fewer than Kh: hold its leading coefficient
			assign kb_next = in_data.kb;
		end else begin : g_kb_step
			logic signed [KB_W+X_W:0] kb_prod;
			assign kb_prod = in_data.kb * $signed({1'b0, in_data.x});
			assign kb_next = KB_W'(kb_prod >>> 20) + KB_COEF[KH_STEPS-1-STEP];
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q.x       <= in_data.x;
			data_q.mol     <= in_data.mol;
			data_q.clamped <= in_data.clamped;
			data_q.kh      <= KH_W'(kh_prod >>> 20) + KH_COEF[KH_STEPS-1-STEP];
			data_q.kb      <= kb_next;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

/* hw/rtl/chcb_exp_cell.sv */
`timescale 1ns / 1ps

module chcb_exp_cell import chcb_pkg::*; #(
	parameter int K = 1
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      in_valid,
	input  chcb_exp_t in_data,
	output logic      out_valid,
	output chcb_exp_t out_data
);

	logic [Z_W+R_W-1:0] zr_prod;
	logic [W_W+31:0]    q_prod;
	logic [W_W-1:0]     w_s1;
	chcb_exp_t          data_s1;
	logic               valid_s1;
	chcb_exp_t          data_s2;
	logic               valid_s2;

	assign zr_prod = in_data.z * in_data.r;
	assign q_prod  = w_s1 * RECIP_M[K];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s1    <= zr_prod[30 +: W_W];
			data_s1 <= in_data;
			data_s2.z       <= data_s1.z;
			data_s2.n       <= data_s1.n;
			data_s2.kh      <= data_s1.kh;
			data_s2.clamped <= data_s1.clamped;
			// next Taylor partial sum: 1 + z*r/k
			data_s2.r       <= ONE_Q30 + R_W'(q_prod >> RECIP_S[K]);
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

/* hw/rtl/co2_henry_coefficient_brine_unit.sv */
`timescale 1ns / 1ps

// Henry coefficient of CO2 in NaCl brine. Each transaction on the slave side carries a
// kelvin temperature and a salt molality; the master side returns the coefficient in
// whole pascals with flags for temperature clamping and output saturation. The unit
// takes one transaction per clock unless a stall on the master side holds the whole
// chain, and returns results in order through five Horner cells for the two
// polynomials, three cells that form the base-2 exponent, twelve two-stage Taylor
// cells for the fractional power of two, then a product and a rounding shift stage.
module co2_henry_coefficient_brine_unit import chcb_pkg::*; #(
	parameter int TEMP_FRAC_BITS = TEMP_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [15:0] temperature_k, [31:16] salt_molality
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [39:0] henry_coef
	output logic [1:0]  m_tuser   // [0] temp_was_clamped, [1] result_saturated
);

	localparam logic [31:0] T_LO = 32'((64'd27315 * (64'd1 << TEMP_FRAC_BITS) + 64'd50) / 64'd100);
	localparam logic [31:0] T_HI = 32'((64'd62315 * (64'd1 << TEMP_FRAC_BITS) + 64'd50) / 64'd100);

	logic              en;
	logic [31:0]       traw;
	logic [31:0]       tc;
	logic [63:0]       d_shift;
	logic              clamped;
	chcb_hrn_t         hrn_d [0:KH_STEPS];
	logic              hrn_v [0:KH_STEPS];

	logic signed [MOL_W+KB_W:0] e_prod;
	logic signed [E_W-1:0]      e_s1;
	logic signed [KH_W-1:0]     kh_s1;
	logic                       clamped_s1;
	logic                       valid_s1;

	logic signed [E_W+32:0]     y_prod;
	logic signed [Y_W-1:0]      y_s2;
	logic signed [KH_W-1:0]     kh_s2;
	logic                       clamped_s2;
	logic                       valid_s2;

	logic [F_W+Z_W-1:0]         z_prod;
	logic [Z_W-1:0]             z_s3;
	logic signed [N_W-1:0]      n_s3;
	logic signed [KH_W-1:0]     kh_s3;
	logic                       clamped_s3;
	logic                       valid_s3;

	chcb_exp_t                  exp_d [0:EXP_TERMS];
	logic                       exp_v [0:EXP_TERMS];

	logic [R_W:0]               r_round;
	logic [P_W-1:0]             p;
	logic [KH_W+P_W-1:0]        v_prod;
	logic [V_W-1:0]             v_s4;
	logic signed [N_W-1:0]      n_s4;
	logic                       kh_neg_s4;
	logic                       kh_zero_s4;
	logic                       clamped_s4;
	logic                       valid_s4;

	logic signed [N_W+1:0]      s;
	logic [N_W+1:0]             sh;
	logic [V_W-1:0]             rounded;
	logic [HENRY_W-1:0]         henry;
	logic                       sat;

	logic                       out_valid_q;
	logic [HENRY_W-1:0]         henry_q;
	logic                       clamped_q;
	logic                       sat_q;

	// the whole chain advances unless a result sits untaken at the output
	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;

	// clamp and convert to Celsius, x = t/512 in Q20
	always_comb begin
		traw    = {16'd0, s_tdata[15:0]};
		tc      = traw;
		clamped = 1'b0;
		priority if (traw < T_LO) begin
			tc      = T_LO;
			clamped = 1'b1;
		end else if (traw > T_HI) begin
			tc      = T_HI;
			clamped = 1'b1;
		end else begin
			tc      = traw;
		end
		d_shift = {32'd0, tc - T_LO} << (24 - TEMP_FRAC_BITS);
	end

	always_comb begin
		hrn_d[0].x       = X_W'(d_shift >> 13);
		hrn_d[0].mol     = s_tdata[31:16];
		hrn_d[0].clamped = clamped;
		hrn_d[0].kh      = KH_COEF[KH_STEPS];
		hrn_d[0].kb      = KB_COEF[KH_STEPS-1];
		hrn_v[0]         = s_tvalid;
	end

	generate
		for (genvar i = 0; i < KH_STEPS; i++) begin : g_hrn
			chcb_horner_cell #(.STEP(i)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.en       (en),
				.in_valid (hrn_v[i]),
				.in_data  (hrn_d[i]),
				.out_valid(hrn_v[i+1]),
				.out_data (hrn_d[i+1])
			);
		end
	endgenerate

	assign e_prod = $signed({1'b0, hrn_d[KH_STEPS].mol}) * hrn_d[KH_STEPS].kb;
	assign y_prod = e_s1 * $signed({1'b0, LOG2_10_Q30});
	assign z_prod = y_s2[F_W-1:0] * LN2_Q30;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= hrn_v[KH_STEPS];
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= exp_v[EXP_TERMS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s1       <= E_W'(e_prod >>> 14);
			kh_s1      <= hrn_d[KH_STEPS].kh;
			clamped_s1 <= hrn_d[KH_STEPS].clamped;

			y_s2       <= Y_W'(y_prod >>> 30);
			kh_s2      <= kh_s1;
			clamped_s2 <= clamped_s1;

			z_s3       <= Z_W'(z_prod >> 28);
			n_s3       <= N_W'(y_s2 >>> 28);
			kh_s3      <= kh_s2;
			clamped_s3 <= clamped_s2;
		end
	end

	always_comb begin
		exp_d[0].z       = z_s3;
		exp_d[0].r       = ONE_Q30;
		exp_d[0].n       = n_s3;
		exp_d[0].kh      = kh_s3;
		exp_d[0].clamped = clamped_s3;
		exp_v[0]         = valid_s3;
	end

	generate
		for (genvar j = 0; j < EXP_TERMS; j++) begin : g_exp
			chcb_exp_cell #(.K(EXP_TERMS - j)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.en       (en),
				.in_valid (exp_v[j]),
				.in_data  (exp_d[j]),
				.out_valid(exp_v[j+1]),
				.out_data (exp_d[j+1])
			);
		end
	endgenerate

	// round 2^f to Q24 and scale Kh
	assign r_round = {1'b0, exp_d[EXP_TERMS].r} + (R_W+1)'(32);
	assign p       = r_round[6 +: P_W];
	assign v_prod  = $unsigned(exp_d[EXP_TERMS].kh) * p;

	always_ff @(posedge clk) begin
		if (en) begin
			v_s4       <= v_prod[V_W-1:0];
			n_s4       <= exp_d[EXP_TERMS].n;
			kh_neg_s4  <= exp_d[EXP_TERMS].kh[KH_W-1];
			kh_zero_s4 <= (exp_d[EXP_TERMS].kh == '0);
			clamped_s4 <= exp_d[EXP_TERMS].clamped;
		end
	end

	// apply the integer power of two and round half up to pascals
	always_comb begin
		s       = (N_W+2)'(n_s4) - (N_W+2)'(28);
		sh      = (N_W+2)'(0) - s;
		rounded = '0;
		henry   = '0;
		sat     = 1'b0;
		priority if (kh_neg_s4) begin
			sat = 1'b1;
		end else if (kh_zero_s4) begin
			sat = 1'b0;
		end else if (s >= 0) begin
			if (s >= 40 || v_s4 > (OUT_MAX >> s)) begin
				henry = '1;
				sat   = 1'b1;
			end else begin
				henry = HENRY_W'(v_s4 << s);
			end
		end else if (sh >= 64) begin
			henry = '0;
		end else begin
			rounded = (v_s4 + (64'd1 << (sh[5:0] - 6'd1))) >> sh[5:0];
			if (rounded > OUT_MAX) begin
				henry = '1;
				sat   = 1'b1;
			end else begin
				henry = rounded[HENRY_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			henry_q   <= henry;
			clamped_q <= clamped_s4;
			sat_q     <= sat;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = henry_q;
	assign m_tuser  = {sat_q, clamped_q};

`ifndef ASSERT_OFF
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && sat_q) |-> (henry_q == '1 || henry_q == '0))
		else $error("saturated result is neither full scale nor zero");

	a_exp_range: assert property (@(posedge clk) disable iff (!arst_n)
		exp_v[EXP_TERMS] |-> (exp_d[EXP_TERMS].r >= ONE_Q30 && !exp_d[EXP_TERMS].r[R_W-1]))
		else $error("fractional power of two left [1, 2)");
`endif

endmodule
